[rtl/core/plt_pkg.sv]
// Shared types and constants for the piecewise linear table lookup block.
// Used by every module under rtl/core; depends on nothing else.
package plt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int DATA_W      = 32;

  // Quotient magnitude is clamped to 2^40 before the final add.
  localparam int MAG_W       = 41;
  localparam int SUM_W       = MAG_W + 1;

  localparam int PROD_W      = 2 * DATA_W;
  localparam int MUL_STEPS   = DATA_W;
  localparam int DIV_STEPS   = PROD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_INTERIOR = 3'd0,
    ST_BELOW    = 3'd1,
    ST_ABOVE    = 3'd2,
    ST_EQUAL    = 3'd3,
    ST_SAT      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_RD0,
    SQ_RDL,
    SQ_CHKL,
    SQ_SCAN,
    SQ_FB,
    SQ_FO,
    SQ_CALC,
    SQ_WAIT,
    SQ_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_MUL,
    AR_DIV
  } arith_state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wx;
    logic [DATA_W-1:0] wy;
  } knot_ram_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } knot_ram_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W:0]   dy_mag;
    logic [DATA_W-1:0] dp_mag;
    logic [DATA_W-1:0] dx_mag;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] mag;
  } arith_rsp_t;

endpackage

[rtl/core/plt_knot_ram.sv]
// Single-port knot table: abscissa and ordinate memories sharing one address.
// Read data is registered. Depends on plt_pkg.
module plt_knot_ram
  import plt_pkg::*;
(
  input  logic          clk,
  input  knot_ram_req_t req,
  output knot_ram_rsp_t rsp
);

  logic [DATA_W-1:0] x_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] y_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] rd_x_r;
  logic [DATA_W-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      x_mem[req.addr] <= req.wx;
      y_mem[req.addr] <= req.wy;
    end else if (req.re) begin
      rd_x_r <= x_mem[req.addr];
      rd_y_r <= y_mem[req.addr];
    end
  end

  assign rsp.x = rd_x_r;
  assign rsp.y = rd_y_r;

endmodule

[rtl/core/plt_muldiv.sv]
// Serial magnitude unit: shift-add multiply of |dy| by |dp|, then a restoring
// divide by |dx|, one bit per cycle. Depends on plt_pkg.
module plt_muldiv
  import plt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  localparam logic [PROD_W-1:0] MAG_CLAMP = PROD_W'(1) << (MAG_W - 1);

  arith_state_t      state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] mcand_r;
  logic [DATA_W-1:0] mplier_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] acc_nxt;
  logic [DATA_W-1:0] divisor_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] rem_nxt;
  logic [PROD_W-1:0] quot_r;
  logic [DATA_W:0]   trial;
  logic              q_bit;
  logic [STEP_W-1:0] step_r;
  logic              mul_last;
  logic              div_last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AR_IDLE: if (req.start) state_nxt = AR_MUL;
      AR_MUL:  if (mul_last)  state_nxt = AR_DIV;
      AR_DIV:  if (div_last)  state_nxt = AR_IDLE;
      default: state_nxt = AR_IDLE;
    endcase
  end

  always_comb begin
    mul_last = 1'b0;
    div_last = 1'b0;
    unique case (state_r)
      AR_MUL:  mul_last = (step_r == STEP_W'(MUL_STEPS - 1));
      AR_DIV:  div_last = (step_r == STEP_W'(DIV_STEPS - 1));
      default: ;
    endcase
    done_nxt = div_last;
  end

  assign acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign trial   = {rem_r, quot_r[PROD_W-1]};
  assign q_bit   = (trial >= {1'b0, divisor_r});
  assign rem_nxt = q_bit ? DATA_W'(trial - {1'b0, divisor_r}) : trial[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      AR_IDLE: begin
        if (req.start) begin
          mcand_r   <= PROD_W'(req.dy_mag);
          mplier_r  <= req.dp_mag;
          divisor_r <= req.dx_mag;
          acc_r     <= '0;
          step_r    <= '0;
        end
      end
      AR_MUL: begin
        acc_r    <= acc_nxt;
        mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[DATA_W-1:1]};
        step_r   <= step_r + STEP_W'(1);
        if (mul_last) begin
          quot_r <= acc_nxt;
          rem_r  <= '0;
          step_r <= '0;
        end
      end
      AR_DIV: begin
        // The dividend shifts out of the top while quotient bits enter below.
        quot_r <= {quot_r[PROD_W-2:0], q_bit};
        rem_r  <= rem_nxt;
        step_r <= step_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.mag  = (quot_r > MAG_CLAMP) ? MAG_CLAMP[MAG_W-1:0] : quot_r[MAG_W-1:0];

endmodule

[rtl/core/plt_seq.sv]
// Query sequencer: accepts items, writes knots, scans the table for the
// segment, launches the magnitude unit and forms the saturated result.
// Depends on plt_pkg; drives plt_knot_ram and plt_muldiv.
module plt_seq
  import plt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [IDX_W-1:0]  in_knot_index,
  input  logic [DATA_W-1:0] in_knot_x,
  input  logic [DATA_W-1:0] in_knot_y,
  input  logic [DATA_W-1:0] in_query_p,
  input  logic [CNT_W-1:0]  knots_in_use,
  output knot_ram_req_t     ram_req,
  input  knot_ram_rsp_t     ram_rsp,
  output arith_req_t        arith_req,
  input  arith_rsp_t        arith_rsp,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [DATA_W-1:0] res_value,
  output status_t           res_status
);

  seq_state_t        state_r, state_nxt;
  logic [DATA_W-1:0] p_r;
  logic [IDX_W-1:0]  last_r;
  logic [IDX_W-1:0]  last_in;
  logic [IDX_W-1:0]  a_r;
  logic [IDX_W-1:0]  b_r;
  logic [IDX_W-1:0]  o_r;
  status_t           region_r;
  logic [DATA_W-1:0] bx_r;
  logic [DATA_W-1:0] by_r;
  logic              neg_r;
  logic [DATA_W-1:0] res_value_r;
  status_t           res_status_r;

  logic              is_query;
  logic              below_first;
  logic              above_last;
  logic              scan_more;
  logic [DATA_W:0]   dx;
  logic [DATA_W:0]   dy;
  logic [DATA_W:0]   dp;
  logic [DATA_W:0]   dy_abs;
  logic [DATA_W:0]   dp_abs;
  logic [DATA_W:0]   dx_abs;
  logic              dx_zero;
  logic [SUM_W-1:0]  sum;
  logic              sum_fits;
  logic [DATA_W-1:0] sat_value;

  // Knot count clamped to [2, TABLE_DEPTH], kept as the index of the last knot.
  always_comb begin
    if (knots_in_use < CNT_W'(2)) begin
      last_in = IDX_W'(1);
    end else if (knots_in_use > CNT_W'(TABLE_DEPTH)) begin
      last_in = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_in = IDX_W'(knots_in_use - CNT_W'(1));
    end
  end

  assign is_query    = (in_func == FUNC_QUERY);
  assign below_first = (p_r <= ram_rsp.x);
  assign above_last  = (p_r >= ram_rsp.x);
  assign scan_more   = (a_r < last_r) && (ram_rsp.x < p_r);

  assign dx      = {1'b0, ram_rsp.x} - {1'b0, bx_r};
  assign dy      = {ram_rsp.y[DATA_W-1], ram_rsp.y} - {by_r[DATA_W-1], by_r};
  assign dp      = {1'b0, p_r} - {1'b0, bx_r};
  assign dy_abs  = dy[DATA_W] ? -dy : dy;
  assign dp_abs  = dp[DATA_W] ? -dp : dp;
  assign dx_abs  = dx[DATA_W] ? -dx : dx;
  assign dx_zero = (dx == '0);

  assign sum = neg_r ? ({{(SUM_W-DATA_W){by_r[DATA_W-1]}}, by_r} - {1'b0, arith_rsp.mag})
                     : ({{(SUM_W-DATA_W){by_r[DATA_W-1]}}, by_r} + {1'b0, arith_rsp.mag});
  assign sum_fits  = (&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]);
  assign sat_value = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: if (in_valid && is_query) state_nxt = SQ_RD0;
      SQ_RD0:  state_nxt = SQ_RDL;
      SQ_RDL:  state_nxt = below_first ? SQ_FB : SQ_CHKL;
      SQ_CHKL: state_nxt = above_last ? SQ_FB : SQ_SCAN;
      SQ_SCAN: if (!scan_more) state_nxt = SQ_FB;
      SQ_FB:   state_nxt = SQ_FO;
      SQ_FO:   state_nxt = SQ_CALC;
      SQ_CALC: state_nxt = dx_zero ? SQ_DONE : SQ_WAIT;
      SQ_WAIT: if (arith_rsp.done) state_nxt = SQ_DONE;
      SQ_DONE: if (res_ready) state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    ram_req.we       = 1'b0;
    ram_req.re       = 1'b0;
    ram_req.addr     = '0;
    ram_req.wx       = in_knot_x;
    ram_req.wy       = in_knot_y;
    arith_req.start  = 1'b0;
    arith_req.dy_mag = dy_abs;
    arith_req.dp_mag = dp_abs[DATA_W-1:0];
    arith_req.dx_mag = dx_abs[DATA_W-1:0];
    unique case (state_r)
      SQ_IDLE: begin
        in_ready     = 1'b1;
        ram_req.addr = in_knot_index;
        ram_req.we   = in_valid && !is_query &&
                       ({1'b0, in_knot_index} < CNT_W'(TABLE_DEPTH));
      end
      SQ_RD0: begin
        ram_req.re = 1'b1;
      end
      SQ_RDL: begin
        ram_req.re   = 1'b1;
        ram_req.addr = last_r;
      end
      SQ_CHKL: begin
        ram_req.re   = 1'b1;
        ram_req.addr = IDX_W'(1);
      end
      SQ_SCAN: begin
        ram_req.re   = 1'b1;
        ram_req.addr = a_r + IDX_W'(1);
      end
      SQ_FB: begin
        ram_req.re   = 1'b1;
        ram_req.addr = b_r;
      end
      SQ_FO: begin
        ram_req.re   = 1'b1;
        ram_req.addr = o_r;
      end
      SQ_CALC: begin
        arith_req.start = !dx_zero;
      end
      SQ_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      SQ_IDLE: begin
        p_r    <= in_query_p;
        last_r <= last_in;
      end
      SQ_RDL: begin
        b_r      <= '0;
        o_r      <= IDX_W'(1);
        region_r <= ST_BELOW;
      end
      SQ_CHKL: begin
        // At or above the last knot the base is the last knot, toward the one before.
        b_r      <= last_r;
        o_r      <= last_r - IDX_W'(1);
        region_r <= ST_ABOVE;
        a_r      <= IDX_W'(1);
      end
      SQ_SCAN: begin
        a_r      <= a_r + IDX_W'(1);
        b_r      <= a_r - IDX_W'(1);
        o_r      <= a_r;
        region_r <= ST_INTERIOR;
      end
      SQ_FO: begin
        bx_r <= ram_rsp.x;
        by_r <= ram_rsp.y;
      end
      SQ_CALC: begin
        neg_r        <= dy[DATA_W] ^ dp[DATA_W] ^ dx[DATA_W];
        res_value_r  <= by_r;
        res_status_r <= ST_EQUAL;
      end
      SQ_WAIT: begin
        if (arith_rsp.done) begin
          res_value_r  <= sum_fits ? sum[DATA_W-1:0] : sat_value;
          res_status_r <= sum_fits ? region_r : ST_SAT;
        end
      end
      default: ;
    endcase
  end

  assign res_value  = res_value_r;
  assign res_status = res_status_r;

endmodule

[rtl/core/piecewise_linear_table_lookup.sv]
// Top level of the piecewise linear table lookup: knot count register,
// result register and the wiring of plt_seq, plt_knot_ram and plt_muldiv.
// Depends on plt_pkg.
//
//   Channel  Direction  Handshake           Payload
//   in_      slave      in_tvalid/tready    tuser: func; tdata: index, x, y, p
//   out_     master     out_tvalid/tready   tuser: status; tdata: value
//   cfg_     slave      cfg_valid/ready     cfg_data: knots_in_use
//
// A knot write is written into the table at its transfer. A query holds in_tready
// low while it finds its segment (inside the table a linear scan reads 1 to n-1
// knots one per cycle from the single-port table), then during the bit-serial
// multiply, divide and hand-back, which equal knots skip. A result that finds the
// output register full adds its wait.
// Reset sets knots_in_use to 1024; table contents are undefined until written.
// A finished result waits in the output register while the next item is taken.
module piecewise_linear_table_lookup
  import plt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [111:0]       in_tdata,   // knot_index[9:0], knot_x, knot_y, query_p, zero fill
  input  logic [0:0]         in_tuser,   // func
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DATA_W-1:0]  out_tdata,  // value
  output logic [2:0]         out_tuser,  // status
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data
);

  logic [CNT_W-1:0]  knots_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  status_t           out_status_r;

  knot_ram_req_t     ram_req;
  knot_ram_rsp_t     ram_rsp;
  arith_req_t        arith_req;
  arith_rsp_t        arith_rsp;
  logic              res_valid;
  logic              res_ready;
  logic [DATA_W-1:0] res_value;
  status_t           res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knots_r <= CNT_W'(TABLE_DEPTH);
    end else if (cfg_valid) begin
      knots_r <= cfg_data;
    end
  end

  plt_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_func       (in_tuser[0]),
    .in_knot_index (in_tdata[9:0]),
    .in_knot_x     (in_tdata[41:10]),
    .in_knot_y     (in_tdata[73:42]),
    .in_query_p    (in_tdata[105:74]),
    .knots_in_use  (knots_r),
    .ram_req       (ram_req),
    .ram_rsp       (ram_rsp),
    .arith_req     (arith_req),
    .arith_rsp     (arith_rsp),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_value     (res_value),
    .res_status    (res_status)
  );

  plt_knot_ram u_ram (
    .clk (clk),
    .req (ram_req),
    .rsp (ram_rsp)
  );

  plt_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  // The output register takes a new result when it is empty or its current one is transferred.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == FUNC_QUERY) |=> !in_tready)
    else $error("input taken while a query is in progress");

  a_arith_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    arith_rsp.done |-> !in_tready)
    else $error("magnitude result returned with no query in progress");

  a_write_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (in_tvalid && in_tready && in_tuser[0] == FUNC_WRITE))
    else $error("table written without a knot write transfer");
`endif

endmodule

[tb/piecewise_linear_table_lookup_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_table_lookup: loads knot tables, sends queries
// and compares every result with its own interpolation model. Depends on plt_pkg and the RTL.
module piecewise_linear_table_lookup_tb;
  import plt_pkg::*;

  localparam int ITEM_TARGET    = 950;
  localparam int IDLE_MAX       = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int WRITE_SETTLE   = 16;
  localparam int END_TAIL       = 200;
  localparam longint unsigned MAG_CLAMP = 64'h100_0000_0000;

  typedef struct {
    func_t             func;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] p;
  } knot_item_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    status_t           status;
  } lookup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [111:0]       in_tdata = '0;    // knot_index[9:0], knot_x, knot_y, query_p, zero fill
  logic [0:0]         in_tuser = '0;    // func
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [DATA_W-1:0]  out_tdata;        // value
  logic [2:0]         out_tuser;        // status
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data = '0;

  // Stimulus side.
  knot_item_t        pending_items[$];
  knot_item_t        next_item;
  logic [DATA_W-1:0] plan_x [TABLE_DEPTH];
  int                queued_count = 0;
  int                send_idle_max = IDLE_MAX;
  int                recv_idle_max = IDLE_MAX;
  int                send_gap = 0;
  int                recv_stall = 0;
  int                recv_draw;
  int                settings_used = 0;

  // Model of the block.
  logic [DATA_W-1:0] knot_x_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] knot_y_mem [TABLE_DEPTH];
  int                knot_count_reg = TABLE_DEPTH;
  lookup_t           pending_results[$];
  lookup_t           expected_result;
  int                accepted_count = 0;
  int                write_count = 0;
  int                query_count = 0;
  int                result_count = 0;
  int                mismatches = 0;
  int                status_seen [5] = '{default: 0};
  int                quiet_cycles = 0;

  piecewise_linear_table_lookup i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic lookup_t interpolate(logic [DATA_W-1:0] p);
    int unsigned       n, last, a, b, o;
    status_t           region;
    longint            bx, ox, by, oy, dx, dy, dp, r;
    longint unsigned   mdy, mdp, mdx, mag;
    logic              negative;
    lookup_t           res;
    n = (knot_count_reg < 2) ? 2 : (knot_count_reg > TABLE_DEPTH) ? TABLE_DEPTH : knot_count_reg;
    last = n - 1;
    if (p <= knot_x_mem[0]) begin
      b = 0;
      o = 1;
      region = ST_BELOW;
    end else if (p >= knot_x_mem[last]) begin
      b = last;
      o = last - 1;
      region = ST_ABOVE;
    end else begin
      a = 1;
      while (a < last && knot_x_mem[a] < p) a++;
      b = a - 1;
      o = a;
      region = ST_INTERIOR;
    end
    bx = longint'(knot_x_mem[b]);
    ox = longint'(knot_x_mem[o]);
    by = longint'($signed(knot_y_mem[b]));
    oy = longint'($signed(knot_y_mem[o]));
    dx = ox - bx;
    dy = oy - by;
    dp = longint'(p) - bx;
    if (dx == 0) begin
      res.value = knot_y_mem[b];
      res.status = ST_EQUAL;
    end else begin
      negative = ((dy < 0) != (dp < 0)) != (dx < 0);
      mdy = (dy < 0) ? -dy : dy;
      mdp = (dp < 0) ? -dp : dp;
      mdx = (dx < 0) ? -dx : dx;
      // The product of the two magnitudes stays below 2^64.
      mag = (mdy * mdp) / mdx;
      if (mag > MAG_CLAMP) mag = MAG_CLAMP;
      r = negative ? by - $signed(mag) : by + $signed(mag);
      res.status = region;
      if (r > longint'(32'h7FFF_FFFF)) begin
        r = 32'h7FFF_FFFF;
        res.status = ST_SAT;
      end else if (r < -longint'(64'h8000_0000)) begin
        r = -longint'(64'h8000_0000);
        res.status = ST_SAT;
      end
      res.value = r[DATA_W-1:0];
    end
    return res;
  endfunction

  // Input driver: a random gap is drawn with every item and kept before the next one is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_item.func;
        in_tdata <= {6'b0, next_item.p, next_item.y, next_item.x, next_item.index};
        send_gap <= $urandom_range(0, send_idle_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure: a stall is drawn after every result transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      recv_draw = $urandom_range(0, recv_idle_max);
      out_tready <= (recv_draw == 0);
      recv_stall <= recv_draw;
    end else if (recv_stall != 0) begin
      out_tready <= (recv_stall == 1);
      recv_stall <= recv_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: tracks the register, predicts each query and checks each result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) knot_count_reg = cfg_data;
      if (out_tvalid && out_tready) begin
        result_count++;
        if (pending_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("result %0d with no query outstanding: value %h status %0d",
                     result_count, out_tdata, out_tuser);
          mismatches++;
        end else begin
          expected_result = pending_results.pop_front();
          status_seen[expected_result.status]++;
          if (out_tdata !== expected_result.value || out_tuser !== expected_result.status) begin
            if (mismatches < MAX_REPORTS)
              $display("result %0d: expected value %h status %0d, got value %h status %0d",
                       result_count, expected_result.value, expected_result.status,
                       out_tdata, out_tuser);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        accepted_count++;
        if (func_t'(in_tuser[0]) == FUNC_WRITE) begin
          knot_x_mem[in_tdata[9:0]] = in_tdata[41:10];
          knot_y_mem[in_tdata[9:0]] = in_tdata[73:42];
          write_count++;
        end else begin
          pending_results.insert(pending_results.size(), interpolate(in_tdata[105:74]));
          query_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(func_t f, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] x,
                            logic [DATA_W-1:0] y, logic [DATA_W-1:0] p);
    knot_item_t item;
    item.func = f;
    item.index = idx;
    item.x = x;
    item.y = y;
    item.p = p;
    pending_items.insert(pending_items.size(), item);
    queued_count++;
    if (f == FUNC_WRITE) plan_x[idx] = x;
  endtask

  task automatic write_knot(int idx, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
    queue_item(FUNC_WRITE, idx[IDX_W-1:0], x, y, $urandom);
  endtask

  task automatic ask(logic [DATA_W-1:0] p);
    queue_item(FUNC_QUERY, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom, $urandom, p);
  endtask

  task automatic set_knot_count(int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  // Writes produce no result, so a short settle follows the last outstanding one.
  task automatic wait_drained();
    while (accepted_count != queued_count || pending_results.size() != 0) @(negedge clk);
    repeat (WRITE_SETTLE) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] draw_ordinate();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] draw_probe(int m);
    logic [DATA_W-1:0] lo, hi;
    lo = plan_x[0];
    hi = plan_x[m-1];
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2, 3, 4: return (lo < hi) ? $urandom_range(hi, lo) : $urandom;
      5: return plan_x[$urandom_range(0, m - 1)] + $urandom_range(0, 2) - 1;
      6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(0, 1) ? lo - $urandom_range(0, 64)
                                           : hi + $urandom_range(0, 64);
    endcase
  endfunction

  // Shape 0 is strictly increasing, 1 increasing with repeated abscissas, 2 unordered.
  task automatic load_table(int m, int shape);
    longint unsigned span, stride, base;
    logic [DATA_W-1:0] x;
    if ($urandom_range(0, 3) == 0) begin
      span = $urandom_range(m, 32'hFFFF_FFFF);
      base = $urandom_range(0, DATA_W'(64'h1_0000_0000 - span));
    end else begin
      span = 64'h1_0000_0000;
      base = 0;
    end
    stride = span / m;
    for (int i = 0; i < m; i++) begin
      x = DATA_W'(base + i * stride + $urandom_range(0, DATA_W'(stride - 1)));
      if (shape == 1 && i > 0 && $urandom_range(0, 3) == 0) x = plan_x[i-1];
      if (shape == 2) x = $urandom;
      write_knot(i, x, draw_ordinate());
    end
  endtask

  task automatic ask_many(int m, int count);
    for (int k = 0; k < count; k++) begin
      // Occasional rewrites disturb the table between queries.
      if ($urandom_range(0, 9) == 0)
        write_knot($urandom_range(0, m - 1), $urandom, draw_ordinate());
      else if (m < TABLE_DEPTH && $urandom_range(0, 19) == 0)
        write_knot($urandom_range(m, TABLE_DEPTH - 1), $urandom, $urandom);
      else
        ask(draw_probe(m));
    end
  endtask

  initial begin
    int random_items;
    int start_count;
    int v, m, shape;
    random_items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A count below two behaves as two.
    set_knot_count(0);
    write_knot(0, 32'h4000_0000, 32'h0001_0000);
    write_knot(1, 32'hC000_0000, 32'h0003_0000);
    write_knot(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    ask(32'h0);
    ask(32'hFFFF_FFFF);
    ask(32'h8000_0000);
    ask(32'h4000_0000);
    ask(32'hC000_0000);
    // Steep segments drive the sum past both ends of the output range.
    write_knot(0, 32'h0, 32'h7FFF_0000);
    write_knot(1, 32'h1, 32'h8000_0000);
    ask(32'hFFFF_FFFF);
    write_knot(0, 32'h0, 32'h8000_0000);
    write_knot(1, 32'h1, 32'h7FFF_FFFF);
    ask(32'hFFFF_FFFF);
    // Coincident knots return the base ordinate on either side.
    write_knot(0, 32'h1234_5678, 32'h0000_0005);
    write_knot(1, 32'h1234_5678, 32'hFFFF_FFF9);
    ask(32'h0);
    ask(32'hFFFF_FFFF);
    random_items += queued_count;
    wait_drained();

    for (int phase = 0; random_items < ITEM_TARGET; phase++) begin
      case ($urandom_range(0, 3))
        0: begin send_idle_max = 0;        recv_idle_max = 0;        end
        1: begin send_idle_max = IDLE_MAX; recv_idle_max = 0;        end
        2: begin send_idle_max = 0;        recv_idle_max = IDLE_MAX; end
        default: begin send_idle_max = IDLE_MAX; recv_idle_max = IDLE_MAX; end
      endcase
      start_count = queued_count;
      if (phase == 3) begin
        // Full table once, then the largest register value on the same table.
        set_knot_count(TABLE_DEPTH);
        load_table(TABLE_DEPTH, 0);
        ask_many(TABLE_DEPTH, 6);
        wait_drained();
        set_knot_count((1 << CNT_W) - 1);
        ask_many(TABLE_DEPTH, 6);
      end else begin
        case ($urandom_range(0, 5))
          0: v = $urandom_range(0, 1);
          1: v = 2;
          2: v = $urandom_range(3, 8);
          3: v = $urandom_range(9, 40);
          default: v = $urandom_range(2, 16);
        endcase
        m = (v < 2) ? 2 : v;
        set_knot_count(v);
        case ($urandom_range(0, 7))
          5, 6: shape = 1;
          7: shape = 2;
          default: shape = 0;
        endcase
        load_table(m, shape);
        ask_many(m, $urandom_range(15, 50));
      end
      random_items += queued_count - start_count;
      wait_drained();
    end

    repeat (END_TAIL) @(posedge clk);
    $display("Covered %0d knot writes and %0d queries over %0d knot-count settings.",
             write_count, query_count, settings_used);
    $display("Results by region: interior %0d, below %0d, above %0d, equal knots %0d, saturated %0d.",
             status_seen[ST_INTERIOR], status_seen[ST_BELOW], status_seen[ST_ABOVE],
             status_seen[ST_EQUAL], status_seen[ST_SAT]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/plt_pkg.sv
rtl/core/plt_knot_ram.sv
rtl/core/plt_muldiv.sv
rtl/core/plt_seq.sv
rtl/core/piecewise_linear_table_lookup.sv
tb/piecewise_linear_table_lookup_tb.sv
